/* hdl/arqsw_pkg.sv */
package arqsw_pkg;

  localparam int WINDOW      = 4;
  localparam int QUEUE_DEPTH = 64;
  localparam int SEQ_BITS    = 32;
  localparam int HANDLE_BITS = 16;
  localparam int LEN_BITS    = 8;
  localparam int MAX_OUT     = 4;

  // window and queue depths are powers of two, pointers wrap by truncation
  localparam int WIN_IDX_W = $clog2(WINDOW);
  localparam int WIN_CNT_W = $clog2(WINDOW + 1);
  localparam int Q_PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_IDX_W = $clog2(MAX_OUT);
  localparam int OUT_CNT_W = $clog2(MAX_OUT + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_ARQ_MODE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LIMIT = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    KIND_SEND    = 2'd0,
    KIND_RX      = 2'd1,
    KIND_TIMEOUT = 2'd2,
    KIND_INVALID = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    MODE_STOP_WAIT = 2'd0,
    MODE_GO_BACK_N = 2'd1,
    MODE_SELECTIVE = 2'd2
  } arq_mode_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_INVALID  = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic [SEQ_BITS-1:0]    seq;
    logic [HANDLE_BITS-1:0] handle;
    logic [LEN_BITS-1:0]    length;
  } desc_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic [SEQ_BITS-1:0]    frame_seq;
    logic [HANDLE_BITS-1:0] frame_handle;
    logic [LEN_BITS-1:0]    frame_length;
    logic                   rx_is_nak;
    logic [SEQ_BITS-1:0]    ref_seq;
  } in_item_t;

  typedef struct packed {
    logic                   tx_valid;
    logic [SEQ_BITS-1:0]    tx_seq;
    logic [HANDLE_BITS-1:0] tx_handle;
    logic [LEN_BITS-1:0]    tx_length;
    logic                   last;
    logic [1:0]             status;
  } out_item_t;

endpackage

/* hdl/arq_sliding_window_sender.sv */
// sliding-window arq sender: stop-and-wait, go-back-n and selective repeat
//
// input channel (in_valid_i / in_stall_o / in_data_i): one beat per event,
// either a send request, a received ack/nak, a timeout or an invalid kind.
// output channel (out_valid_o / out_stall_i / out_data_o): one beat per
// transmission, or a single idle beat when an event sends nothing; the
// final beat of an event carries last. config channel (cfg_valid_i /
// cfg_ready_o): index 0 arq mode, index 1 window limit; always ready. the user
// must write it only while the block is idle; the block does not enforce this.
//
// one event is handled at a time by a small sequencer: it accepts and dispatches
// the event, may walk the window for the shared sequence compare, pulls frames
// from the wait queue (one memory read port) with a check step and a write step
// for each, and then sends the result beats from its output step.
// in_stall_o is low only when the sequencer is idle; the output register
// lets the next event be accepted while the last beat still waits.
// reset empties window and wait queue and sets go-back-n with limit 4.
// a receiver stall just holds the sequencer in its output step.
module arq_sliding_window_sender import arqsw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEARCH,
    S_RESEND,
    S_REFILL_CHK,
    S_REFILL_WR,
    S_OUTPUT
  } state_e;

  state_e                 state_q, state_d;
  in_item_t               item_q;
  logic [1:0]             status_q, status_d;
  logic [1:0]             mode_q;
  logic [2:0]             limit_q;
  logic [WIN_IDX_W-1:0]   win_head_q, win_head_d;
  logic [WIN_CNT_W-1:0]   win_count_q, win_count_d;
  logic [WIN_CNT_W-1:0]   idx_q, idx_d;
  logic [OUT_CNT_W-1:0]   tx_n_q, tx_n_d;
  logic [OUT_IDX_W-1:0]   out_idx_q, out_idx_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_data_q, out_data_d;

  desc_t                  win_q [WINDOW];
  desc_t                  tx_buf_q [MAX_OUT];

  // window store ports
  logic [WIN_IDX_W-1:0]   win_raddr;
  desc_t                  win_rd;
  logic                   win_we;
  logic [WIN_IDX_W-1:0]   win_waddr;

  // result collection
  logic                   emit;
  desc_t                  emit_data;

  // wait queue
  logic                   push, pop;
  desc_t                  fifo_data;
  logic [Q_CNT_W-1:0]     fifo_count;

  logic [WIN_CNT_W-1:0]   eff_lim;
  logic                   is_sel, is_sw;
  logic                   idx_end, seq_hit, found, ack_walk;
  logic [WIN_CNT_W-1:0]   retire_n;
  logic                   out_last;
  logic                   accept;

  arqsw_wait_fifo u_wait_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({item_q.frame_seq, item_q.frame_handle, item_q.frame_length}),
    .pop_i       (pop),
    .pop_data_o  (fifo_data),
    .count_o     (fifo_count)
  );

  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign is_sel = (mode_q == MODE_SELECTIVE);
  assign is_sw  = (mode_q == MODE_STOP_WAIT);

  // effective window: one in stop-and-wait, else limit clamped to 1..window
  always_comb begin
    if (is_sw || limit_q == '0) begin
      eff_lim = WIN_CNT_W'(1);
    end else if (limit_q > 3'(WINDOW)) begin
      eff_lim = WIN_CNT_W'(WINDOW);
    end else begin
      eff_lim = WIN_CNT_W'(limit_q);
    end
  end

  // single window read port, walked by idx_q from the head
  assign win_raddr = win_head_q + idx_q[WIN_IDX_W-1:0];
  assign win_rd    = win_q[win_raddr];
  assign win_waddr = win_head_q + win_count_q[WIN_IDX_W-1:0];

  // shared sequence compare
  assign idx_end  = (idx_q == win_count_q);
  assign seq_hit  = (win_rd.seq == item_q.ref_seq);
  assign found    = !idx_end && seq_hit;
  // an ack walk retires; a selective nak or timeout walk resends
  assign ack_walk = (item_q.kind == KIND_RX) && !(is_sel && item_q.rx_is_nak);
  assign retire_n = found ? idx_q + 1'b1 : win_count_q;

  assign out_last = (tx_n_q == '0) || ({1'b0, out_idx_q} == tx_n_q - 1'b1);

  always_comb begin
    state_d     = state_q;
    status_d    = status_q;
    win_head_d  = win_head_q;
    win_count_d = win_count_q;
    idx_d       = idx_q;
    tx_n_d      = tx_n_q;
    out_idx_d   = out_idx_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    win_we      = 1'b0;
    emit        = 1'b0;
    emit_data   = win_rd;
    push        = 1'b0;
    pop         = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d  = S_DISPATCH;
          status_d = STATUS_OK;
          tx_n_d   = '0;
          idx_d    = '0;
        end
      end

      S_DISPATCH: begin
        case (item_q.kind)
          KIND_SEND: begin
            if (fifo_count == Q_CNT_W'(QUEUE_DEPTH)) begin
              status_d = STATUS_OVERFLOW;
            end else begin
              push = 1'b1;
            end
            state_d = S_REFILL_CHK;
          end
          KIND_RX: begin
            if (is_sw) begin
              // head retires whatever the ack number says
              if (win_count_q != '0) begin
                win_head_d  = win_head_q + 1'b1;
                win_count_d = win_count_q - 1'b1;
              end
              state_d = S_REFILL_CHK;
            end else begin
              state_d = S_SEARCH;
            end
          end
          KIND_TIMEOUT: begin
            if (is_sel) begin
              state_d = S_SEARCH;
            end else if (is_sw) begin
              // idx_q is zero, so the read port shows the head
              emit    = (win_count_q != '0);
              state_d = S_REFILL_CHK;
            end else begin
              state_d = S_RESEND;
            end
          end
          default: begin
            status_d  = STATUS_INVALID;
            out_idx_d = '0;
            state_d   = S_OUTPUT;
          end
        endcase
      end

      S_SEARCH: begin
        if (idx_end || seq_hit) begin
          if (ack_walk) begin
            // cumulative retire; an unmatched ack empties the window
            win_head_d  = win_head_q + retire_n[WIN_IDX_W-1:0];
            win_count_d = win_count_q - retire_n;
          end else begin
            emit = found;
          end
          state_d = S_REFILL_CHK;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_RESEND: begin
        if (idx_end) begin
          state_d = S_REFILL_CHK;
        end else begin
          emit  = 1'b1;
          idx_d = idx_q + 1'b1;
        end
      end

      S_REFILL_CHK: begin
        if (win_count_q < eff_lim && fifo_count != '0) begin
          pop     = 1'b1;
          state_d = S_REFILL_WR;
        end else begin
          out_idx_d = '0;
          state_d   = S_OUTPUT;
        end
      end

      S_REFILL_WR: begin
        win_we      = 1'b1;
        emit        = 1'b1;
        emit_data   = fifo_data;
        win_count_d = win_count_q + 1'b1;
        state_d     = S_REFILL_CHK;
      end

      S_OUTPUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d         = 1'b1;
          out_data_d.tx_valid = (tx_n_q != '0);
          if (tx_n_q != '0) begin
            out_data_d.tx_seq    = tx_buf_q[out_idx_q].seq;
            out_data_d.tx_handle = tx_buf_q[out_idx_q].handle;
            out_data_d.tx_length = tx_buf_q[out_idx_q].length;
          end else begin
            out_data_d.tx_seq    = '0;
            out_data_d.tx_handle = '0;
            out_data_d.tx_length = '0;
          end
          out_data_d.last   = out_last;
          out_data_d.status = status_q;
          if (out_last) begin
            state_d = S_IDLE;
          end else begin
            out_idx_d = out_idx_q + 1'b1;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // results beyond the per-event maximum are dropped
    if (emit && tx_n_q != OUT_CNT_W'(MAX_OUT)) begin
      tx_n_d = tx_n_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      status_q    <= STATUS_OK;
      mode_q      <= MODE_GO_BACK_N;
      limit_q     <= 3'd4;
      win_head_q  <= '0;
      win_count_q <= '0;
      idx_q       <= '0;
      tx_n_q      <= '0;
      out_idx_q   <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      win_head_q  <= win_head_d;
      win_count_q <= win_count_d;
      idx_q       <= idx_d;
      tx_n_q      <= tx_n_d;
      out_idx_q   <= out_idx_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
      if (cfg_valid_i && cfg_index_i == REG_ARQ_MODE) begin
        mode_q <= cfg_data_i[1:0];
      end
      if (cfg_valid_i && cfg_index_i == REG_WINDOW_LIMIT) begin
        limit_q <= cfg_data_i[2:0];
      end
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    if (win_we) begin
      win_q[win_waddr] <= fifo_data;
    end
    if (emit && tx_n_q != OUT_CNT_W'(MAX_OUT)) begin
      tx_buf_q[tx_n_q[OUT_IDX_W-1:0]] <= emit_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // window never holds more than its depth
  a_win_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_count_q <= WIN_CNT_W'(WINDOW))
    else $error("window count above depth");

  // an idle beat is always the only beat of its event
  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.tx_valid |-> out_data_o.last)
    else $error("idle beat without last");

  // an accepted event always enters dispatch next
  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == S_DISPATCH)
    else $error("accepted event not dispatched");

endmodule

/* hdl/arqsw_wait_fifo.sv */
module arqsw_wait_fifo import arqsw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  desc_t              push_data_i,
  input  logic               pop_i,
  output desc_t              pop_data_o,
  output logic [Q_CNT_W-1:0] count_o
);

  desc_t               mem_q [QUEUE_DEPTH];
  desc_t               pop_data_q;
  logic [Q_PTR_W-1:0]  head_q, head_d;
  logic [Q_PTR_W-1:0]  tail_q, tail_d;
  logic [Q_CNT_W-1:0]  count_q, count_d;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (push_i) begin
      tail_d = tail_q + 1'b1;
    end
    if (pop_i) begin
      head_d = head_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // storage and registered read port
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[tail_q] <= push_data_i;
    end
    if (pop_i) begin
      pop_data_q <= mem_q[head_q];
    end
  end

  assign pop_data_o = pop_data_q;
  assign count_o    = count_q;

endmodule
